### design/hcmm_pkg.sv
package hcmm_pkg;

    // Image sizes of the console.
    localparam int CART_ROM_BYTES = 32768;
    localparam int BOOT_BYTES     = 256;

    // The main store is indexed by the bus address itself.
    localparam int MAIN_DEPTH = 65536;
    localparam int BOOT_AW    = (BOOT_BYTES > 1) ? $clog2(BOOT_BYTES) : 1;

    // Fixed points of the memory map.
    localparam logic [15:0] ADDR_OVERLAY_END = 16'h0100;
    localparam logic [15:0] ADDR_EXIT_END    = 16'h1000;
    localparam logic [15:0] ADDR_VRAM        = 16'h8000;
    localparam logic [15:0] ADDR_WRAM_END    = 16'hFDFF;
    localparam logic [15:0] ADDR_OAM         = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_END     = 16'hFE9F;
    localparam logic [15:0] ADDR_HOLE_END    = 16'hFEFF;
    localparam logic [15:0] ADDR_IO          = 16'hFF00;
    localparam logic [15:0] ADDR_IO_END      = 16'hFF7F;
    localparam logic [15:0] ADDR_HRAM        = 16'hFF80;
    localparam logic [15:0] ADDR_HRAM_END    = 16'hFFFE;
    localparam logic [15:0] ADDR_IF          = 16'hFF0F;
    localparam logic [15:0] ADDR_LCDC        = 16'hFF40;
    localparam logic [15:0] ADDR_SCY         = 16'hFF42;
    localparam logic [15:0] ADDR_SCX         = 16'hFF43;
    localparam logic [15:0] ADDR_LY          = 16'hFF44;
    localparam logic [15:0] ADDR_IE          = 16'hFFFF;
    localparam logic [15:0] BOOT_EXIT_PC     = 16'h0100;

    typedef enum logic [1:0] {
        ACT_READ      = 2'd0,
        ACT_WRITE     = 2'd1,
        ACT_LOAD_CART = 2'd2,
        ACT_LOAD_BOOT = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_MAIN,
        SRC_BOOT,
        SRC_IE,
        SRC_IF,
        SRC_LCD,
        SRC_SCY,
        SRC_SCX,
        SRC_LINE
    } t_src;

    typedef enum logic [2:0] {
        REG_NONE,
        REG_IE,
        REG_IF,
        REG_LCD,
        REG_SCY,
        REG_SCX
    } t_reg;

    typedef struct packed {
        t_src src;
        logic err;
        logic main_we;
        logic boot_we;
        t_reg reg_we;
        logic boot_off;
    } t_dec;

    // The four LCD flags sit at bits 0, 3, 4 and 7 of the control byte.
    function automatic logic [7:0] lcd_pack(input logic [3:0] flags);
        return {flags[3], 2'b00, flags[2], flags[1], 2'b00, flags[0]};
    endfunction

    function automatic logic [3:0] lcd_unpack(input logic [7:0] data);
        return {data[7], data[4], data[3], data[0]};
    endfunction

endpackage

### design/hcmm_ram.sv
module hcmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/hcmm_decode.sv
module hcmm_decode (
    input  hcmm_pkg::t_action i_action,
    input  logic [15:0]       i_address,
    input  logic [15:0]       i_program_counter,
    input  logic              i_boot_active,
    output hcmm_pkg::t_dec    o_dec
);
    import hcmm_pkg::*;

    logic in_boot;
    logic in_cart;

    assign in_boot = {1'b0, i_address} < 17'(BOOT_BYTES);
    assign in_cart = {1'b0, i_address} < 17'(CART_ROM_BYTES);

    always_comb begin
        o_dec.src      = SRC_ZERO;
        o_dec.err      = 1'b0;
        o_dec.main_we  = 1'b0;
        o_dec.boot_we  = 1'b0;
        o_dec.reg_we   = REG_NONE;
        o_dec.boot_off = 1'b0;
        unique case (i_action)
            ACT_READ: begin
                priority if (i_address < ADDR_VRAM) begin
                    if (i_boot_active && i_address < ADDR_OVERLAY_END) begin
                        // Overlay offsets past a short boot image read as zero.
                        o_dec.src = in_boot ? SRC_BOOT : SRC_ZERO;
                    end else begin
                        o_dec.boot_off = i_boot_active && i_address < ADDR_EXIT_END
                                         && i_program_counter == BOOT_EXIT_PC;
                        o_dec.src = in_cart ? SRC_MAIN : SRC_ZERO;
                        o_dec.err = !in_cart;
                    end
                end else if (i_address <= ADDR_WRAM_END) begin
                    o_dec.src = SRC_MAIN;
                end else if (i_address == ADDR_IE) begin
                    o_dec.src = SRC_IE;
                end else if (i_address == ADDR_IF) begin
                    o_dec.src = SRC_IF;
                end else if (i_address == ADDR_LCDC) begin
                    o_dec.src = SRC_LCD;
                end else if (i_address == ADDR_SCY) begin
                    o_dec.src = SRC_SCY;
                end else if (i_address == ADDR_SCX) begin
                    o_dec.src = SRC_SCX;
                end else if (i_address == ADDR_LY) begin
                    o_dec.src = SRC_LINE;
                end else if (i_address >= ADDR_OAM && i_address <= ADDR_OAM_END) begin
                    o_dec.src = SRC_MAIN;
                end else if (i_address >= ADDR_HRAM && i_address <= ADDR_HRAM_END) begin
                    o_dec.src = SRC_MAIN;
                end else if (i_address >= ADDR_IO && i_address <= ADDR_IO_END) begin
                    o_dec.src = SRC_MAIN;
                end else begin
                    o_dec.err = 1'b1;
                end
            end
            ACT_WRITE: begin
                priority if (i_address < ADDR_VRAM) begin
                    o_dec.main_we = 1'b0;
                end else if (i_address <= ADDR_WRAM_END) begin
                    o_dec.main_we = 1'b1;
                end else if (i_address == ADDR_IE) begin
                    o_dec.reg_we = REG_IE;
                end else if (i_address == ADDR_IF) begin
                    o_dec.reg_we = REG_IF;
                end else if (i_address == ADDR_LCDC) begin
                    o_dec.reg_we = REG_LCD;
                end else if (i_address == ADDR_SCY) begin
                    o_dec.reg_we = REG_SCY;
                end else if (i_address == ADDR_SCX) begin
                    o_dec.reg_we = REG_SCX;
                end else if (i_address <= ADDR_HOLE_END) begin
                    // Sprite attributes take the write, the hole behind them drops it.
                    o_dec.main_we = i_address <= ADDR_OAM_END;
                end else begin
                    o_dec.main_we = 1'b1;
                end
            end
            ACT_LOAD_CART: begin
                o_dec.main_we = in_cart;
                o_dec.err     = !in_cart;
            end
            ACT_LOAD_BOOT: begin
                o_dec.boot_we = in_boot;
                o_dec.err     = !in_boot;
            end
            default: begin
                o_dec.err = 1'b0;
            end
        endcase
    end

endmodule

### design/handheld_console_memory_map.sv
// Channel   Direction  Handshake          Item fields
// input     in         i_valid / o_stall  action, address, write_data, program_counter,
//                                         current_line
// output    out        o_valid / i_stall  read_data, access_error, lcd_flags, scroll_y,
//                                         scroll_x, boot_active
//
// One item is accepted per cycle when the output side keeps up. Its result is presented
// after the item has passed through the read stage, where the memories deliver its
// byte, and has moved into the result register.
// Reset clears the small registers, sets the boot overlay and empties the pipeline;
// the memories are not cleared. A stall on the output holds the result register and
// the read stage behind it, and o_stall rises while both are full and the output stalls.
module handheld_console_memory_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_program_counter,
    input  logic [7:0]  i_current_line,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_access_error,
    output logic [3:0]  o_lcd_flags,
    output logic [7:0]  o_scroll_y,
    output logic [7:0]  o_scroll_x,
    output logic        o_boot_active
);
    import hcmm_pkg::*;

    // Architectural registers that live outside the memories.
    logic       r_boot;
    logic [7:0] r_ie;
    logic [7:0] r_if;
    logic [3:0] r_lcd;
    logic [7:0] r_scy;
    logic [7:0] r_scx;
    logic       n_boot;
    logic [7:0] n_ie;
    logic [7:0] n_if;
    logic [3:0] n_lcd;
    logic [7:0] n_scy;
    logic [7:0] n_scx;

    // Read stage: the item waits here while the memories deliver its byte.
    logic       r_p_valid;
    t_src       r_p_src;
    logic [7:0] r_p_byte;
    logic       r_p_err;
    logic [3:0] r_p_lcd;
    logic [7:0] r_p_scy;
    logic [7:0] r_p_scx;
    logic       r_p_boot;
    logic [7:0] n_p_byte;

    // Result register.
    logic       r_o_valid;
    logic [7:0] r_o_read_data;
    logic       r_o_err;
    logic [3:0] r_o_lcd;
    logic [7:0] r_o_scy;
    logic [7:0] r_o_scx;
    logic       r_o_boot;
    logic [7:0] n_o_read_data;

    t_dec       dec;
    logic       accept;
    logic       p_move;
    logic [7:0] main_rdata;
    logic [7:0] boot_rdata;

    // The read stage moves on whenever the result register is empty or being taken.
    assign p_move  = r_p_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_p_valid && !p_move;
    assign accept  = i_valid && !o_stall;

    hcmm_decode u_decode (
        .i_action          (t_action'(i_action)),
        .i_address         (i_address),
        .i_program_counter (i_program_counter),
        .i_boot_active     (r_boot),
        .o_dec             (dec)
    );

    // Cartridge ROM, video, external, work, sprite, I/O and high RAM share one store
    // indexed by the bus address; the echo of work RAM has its own entries.
    hcmm_ram #(
        .WIDTH (8),
        .DEPTH (MAIN_DEPTH)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (accept && dec.main_we),
        .i_re    (accept && dec.src == SRC_MAIN),
        .i_addr  (i_address),
        .i_wdata (i_write_data),
        .o_rdata (main_rdata)
    );

    hcmm_ram #(
        .WIDTH (8),
        .DEPTH (BOOT_BYTES)
    ) u_boot_ram (
        .i_clk   (i_clk),
        .i_we    (accept && dec.boot_we),
        .i_re    (accept && dec.src == SRC_BOOT),
        .i_addr  (i_address[BOOT_AW-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (boot_rdata)
    );

    // Register updates of the accepted item.
    always_comb begin
        n_boot = r_boot;
        n_ie   = r_ie;
        n_if   = r_if;
        n_lcd  = r_lcd;
        n_scy  = r_scy;
        n_scx  = r_scx;
        if (accept) begin
            if (dec.boot_off) begin
                n_boot = 1'b0;
            end
            unique case (dec.reg_we)
                REG_IE:   n_ie  = i_write_data;
                REG_IF:   n_if  = i_write_data;
                REG_LCD:  n_lcd = lcd_unpack(i_write_data);
                REG_SCY:  n_scy = i_write_data;
                REG_SCX:  n_scx = i_write_data;
                default:  n_ie  = r_ie;
            endcase
        end
    end

    // Bytes that do not come from a memory are picked when the item is accepted.
    always_comb begin
        unique case (dec.src)
            SRC_IE:   n_p_byte = r_ie;
            SRC_IF:   n_p_byte = r_if;
            SRC_LCD:  n_p_byte = lcd_pack(r_lcd);
            SRC_SCY:  n_p_byte = r_scy;
            SRC_SCX:  n_p_byte = r_scx;
            SRC_LINE: n_p_byte = i_current_line;
            default:  n_p_byte = 8'h00;
        endcase
    end

    always_comb begin
        unique case (r_p_src)
            SRC_MAIN: n_o_read_data = main_rdata;
            SRC_BOOT: n_o_read_data = boot_rdata;
            default:  n_o_read_data = r_p_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot    <= 1'b1;
            r_ie      <= 8'h00;
            r_if      <= 8'h00;
            r_lcd     <= 4'h0;
            r_scy     <= 8'h00;
            r_scx     <= 8'h00;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_boot <= n_boot;
            r_ie   <= n_ie;
            r_if   <= n_if;
            r_lcd  <= n_lcd;
            r_scy  <= n_scy;
            r_scx  <= n_scx;
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers; the state outputs are the values after the item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_src  <= dec.src;
            r_p_byte <= n_p_byte;
            r_p_err  <= dec.err;
            r_p_lcd  <= n_lcd;
            r_p_scy  <= n_scy;
            r_p_scx  <= n_scx;
            r_p_boot <= n_boot;
        end
        if (p_move) begin
            r_o_read_data <= n_o_read_data;
            r_o_err       <= r_p_err;
            r_o_lcd       <= r_p_lcd;
            r_o_scy       <= r_p_scy;
            r_o_scx       <= r_p_scx;
            r_o_boot      <= r_p_boot;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_read_data    = r_o_read_data;
    assign o_access_error = r_o_err;
    assign o_lcd_flags    = r_o_lcd;
    assign o_scroll_y     = r_o_scy;
    assign o_scroll_x     = r_o_scx;
    assign o_boot_active  = r_o_boot;

endmodule
